// ===== hdl/rgblit_pkg.sv =====
`timescale 1ns / 1ps

package rgblit_pkg;

    // screen and font geometry
    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;
    localparam int GLYPH_HEIGHT  = 16;
    localparam int GLYPH_WIDTH   = 8;
    localparam int GLYPH_COUNT   = 256;

    localparam int PIXELS      = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int FRAME_AW    = $clog2(PIXELS);
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int GROW_W      = $clog2(GLYPH_HEIGHT);
    localparam int GCOL_W      = $clog2(GLYPH_WIDTH);
    localparam int SCREEN_MAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    // holds x + width (two 9-bit fields) and any screen bound
    localparam int COORD_W     = $clog2(1024 + SCREEN_MAX + 1);

    localparam logic [8:0] CODE_LIMIT = 9'(GLYPH_COUNT);
    localparam logic [5:0] GROW_LIMIT = 6'(GLYPH_HEIGHT);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        MODE_CLEAR = 3'd0,
        MODE_FILL  = 3'd1,
        MODE_GLYPH = 3'd2,
        MODE_LOAD  = 3'd3,
        MODE_READ  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_GFETCH,
        ST_GPIX,
        ST_RADDR,
        ST_RWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  glyph_bits;
        logic [3:0]  glyph_row;
        logic [7:0]  char_code;
        logic [8:0]  rect_height;
        logic [8:0]  rect_width;
        logic [8:0]  y;
        logic [8:0]  x;
        logic [2:0]  mode;
    } cmd_t;

    typedef struct packed {
        logic        clipped;
        logic [15:0] read_pixel;
    } result_t;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [FRAME_AW-1:0] addr;
        logic [15:0]         wdata;
    } frame_req_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         wdata;
    } font_req_t;

endpackage

// ===== hdl/rgblit_frame_mem.sv =====
`timescale 1ns / 1ps

module rgblit_frame_mem (
    input  logic                    clk,
    input  rgblit_pkg::frame_req_t  req,
    output logic [15:0]             q
);

    logic [15:0] mem [rgblit_pkg::PIXELS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            q <= mem[req.addr];
        end
    end

endmodule

// ===== hdl/rgblit_font_mem.sv =====
`timescale 1ns / 1ps

module rgblit_font_mem (
    input  logic                   clk,
    input  rgblit_pkg::font_req_t  req,
    output logic [7:0]             q
);

    logic [7:0] mem [rgblit_pkg::FONT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            q <= mem[req.addr];
        end
    end

endmodule

// ===== hdl/rgblit_engine.sv =====
`timescale 1ns / 1ps

module rgblit_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  rgblit_pkg::cmd_t        cmd,
    output logic                    cmd_ready,
    input  logic                    out_free,
    output logic                    res_valid,
    output rgblit_pkg::result_t     res,
    output rgblit_pkg::frame_req_t  frame_req,
    input  logic [15:0]             frame_q,
    output rgblit_pkg::font_req_t   font_req,
    input  logic [7:0]              font_q
);

    localparam int CW = rgblit_pkg::COORD_W;
    localparam int AW = rgblit_pkg::FRAME_AW;
    localparam int FW = rgblit_pkg::FONT_AW;
    localparam int GW = rgblit_pkg::GROW_W;
    localparam int BW = rgblit_pkg::GCOL_W;

    localparam logic [CW-1:0] SCR_W      = CW'(rgblit_pkg::SCREEN_WIDTH);
    localparam logic [CW-1:0] SCR_H      = CW'(rgblit_pkg::SCREEN_HEIGHT);
    localparam logic [AW-1:0] GLYPH_STEP =
        AW'(rgblit_pkg::SCREEN_WIDTH - rgblit_pkg::GLYPH_WIDTH + 1);
    localparam logic [GW-1:0] GROW_LAST  = GW'(rgblit_pkg::GLYPH_HEIGHT - 1);
    localparam logic [BW-1:0] GCOL_LAST  = BW'(rgblit_pkg::GLYPH_WIDTH - 1);

    rgblit_pkg::state_t state_reg, state_next;
    rgblit_pkg::cmd_t   cmd_reg;

    logic [CW-1:0] col_reg,       col_next;
    logic [CW-1:0] row_reg,       row_next;
    logic [CW-1:0] col_first_reg, col_first_next;
    logic [CW-1:0] col_end_reg,   col_end_next;
    logic [CW-1:0] row_end_reg,   row_end_next;
    logic [AW-1:0] addr_reg,      addr_next;
    logic [AW-1:0] step_reg,      step_next;
    logic [GW-1:0] grow_reg,      grow_next;
    logic [BW-1:0] gcol_reg,      gcol_next;
    logic          clip_reg,      clip_next;
    logic [15:0]   pix_reg,       pix_next;

    // setup arithmetic
    logic [CW-1:0] x_c, y_c, xe_raw, ye_raw, xe_c, ye_c, span;
    logic [AW-1:0] start_addr;
    logic          fill_zero, fill_clip, fill_none, code_ok, load_ok, read_ok;

    // walk status
    logic          col_last, row_last, gcol_last, grow_last, glyph_bit, on_screen;
    logic [FW-1:0] glyph_base, load_addr, glyph_addr;

    assign x_c        = CW'(cmd_reg.x);
    assign y_c        = CW'(cmd_reg.y);
    assign xe_raw     = x_c + CW'(cmd_reg.rect_width);
    assign ye_raw     = y_c + CW'(cmd_reg.rect_height);
    assign xe_c       = (xe_raw > SCR_W) ? SCR_W : xe_raw;
    assign ye_c       = (ye_raw > SCR_H) ? SCR_H : ye_raw;
    assign span       = xe_c - x_c;
    assign start_addr = AW'(AW'(cmd_reg.y) * AW'(rgblit_pkg::SCREEN_WIDTH)) + AW'(cmd_reg.x);
    assign fill_zero  = (cmd_reg.rect_width == 9'd0) || (cmd_reg.rect_height == 9'd0);
    assign fill_clip  = !fill_zero && ((xe_raw > SCR_W) || (ye_raw > SCR_H));
    assign fill_none  = fill_zero || (x_c >= xe_c) || (y_c >= ye_c);
    assign code_ok    = {1'b0, cmd_reg.char_code} < rgblit_pkg::CODE_LIMIT;
    assign load_ok    = code_ok && ({2'b00, cmd_reg.glyph_row} < rgblit_pkg::GROW_LIMIT);
    assign read_ok    = (x_c < SCR_W) && (y_c < SCR_H);

    assign col_last   = (col_reg == col_end_reg - CW'(1));
    assign row_last   = (row_reg == row_end_reg - CW'(1));
    assign gcol_last  = (gcol_reg == GCOL_LAST);
    assign grow_last  = (grow_reg == GROW_LAST);
    assign glyph_bit  = font_q[GCOL_LAST - gcol_reg];
    assign on_screen  = (col_reg < SCR_W) && (row_reg < SCR_H);

    assign glyph_base = FW'(FW'(cmd_reg.char_code) * FW'(rgblit_pkg::GLYPH_HEIGHT));
    assign load_addr  = glyph_base + FW'(cmd_reg.glyph_row);
    // the next row is prefetched on the last pixel of the current one
    assign glyph_addr = glyph_base + FW'((state_reg == rgblit_pkg::ST_GFETCH) ?
                                         grow_reg : grow_reg + GW'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rgblit_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = rgblit_pkg::ST_SETUP;
                end
            end
            rgblit_pkg::ST_SETUP:
            begin
                case (cmd_reg.mode)
                    rgblit_pkg::MODE_CLEAR: state_next = rgblit_pkg::ST_FILL;
                    rgblit_pkg::MODE_FILL:
                        state_next = fill_none ? rgblit_pkg::ST_DONE : rgblit_pkg::ST_FILL;
                    rgblit_pkg::MODE_GLYPH:
                        state_next = code_ok ? rgblit_pkg::ST_GFETCH : rgblit_pkg::ST_DONE;
                    rgblit_pkg::MODE_READ:
                        state_next = read_ok ? rgblit_pkg::ST_RADDR : rgblit_pkg::ST_DONE;
                    default:                state_next = rgblit_pkg::ST_DONE;
                endcase
            end
            rgblit_pkg::ST_FILL:
            begin
                if (col_last && row_last)
                begin
                    state_next = rgblit_pkg::ST_DONE;
                end
            end
            rgblit_pkg::ST_GFETCH: state_next = rgblit_pkg::ST_GPIX;
            rgblit_pkg::ST_GPIX:
            begin
                if (gcol_last && grow_last)
                begin
                    state_next = rgblit_pkg::ST_DONE;
                end
            end
            rgblit_pkg::ST_RADDR:  state_next = rgblit_pkg::ST_RWAIT;
            rgblit_pkg::ST_RWAIT:  state_next = rgblit_pkg::ST_DONE;
            rgblit_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rgblit_pkg::ST_IDLE;
                end
            end
            default:               state_next = rgblit_pkg::ST_IDLE;
        endcase
    end

    // datapath: one address adder and one coordinate counter pair, reused by the clear, fill and glyph walks
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        col_first_next = col_first_reg;
        col_end_next   = col_end_reg;
        row_end_next   = row_end_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        grow_next      = grow_reg;
        gcol_next      = gcol_reg;
        clip_next      = clip_reg;
        pix_next       = pix_reg;
        case (state_reg)
            rgblit_pkg::ST_SETUP:
            begin
                pix_next       = 16'd0;
                clip_next      = 1'b0;
                col_next       = x_c;
                row_next       = y_c;
                col_first_next = x_c;
                col_end_next   = xe_c;
                row_end_next   = ye_c;
                addr_next      = start_addr;
                step_next      = AW'(rgblit_pkg::SCREEN_WIDTH) - AW'(span) + AW'(1);
                grow_next      = '0;
                gcol_next      = '0;
                case (cmd_reg.mode)
                    rgblit_pkg::MODE_CLEAR:
                    begin
                        col_next       = '0;
                        row_next       = '0;
                        col_first_next = '0;
                        col_end_next   = SCR_W;
                        row_end_next   = SCR_H;
                        addr_next      = '0;
                        step_next      = AW'(1);
                    end
                    rgblit_pkg::MODE_FILL: clip_next = fill_clip;
                    rgblit_pkg::MODE_READ: clip_next = !read_ok;
                    default:               clip_next = 1'b0;
                endcase
            end
            rgblit_pkg::ST_FILL:
            begin
                if (col_last)
                begin
                    col_next  = col_first_reg;
                    row_next  = row_reg + CW'(1);
                    addr_next = addr_reg + step_reg;
                end
                else
                begin
                    col_next  = col_reg + CW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            rgblit_pkg::ST_GPIX:
            begin
                if (glyph_bit && !on_screen)
                begin
                    clip_next = 1'b1;
                end
                if (gcol_last)
                begin
                    gcol_next = '0;
                    grow_next = grow_reg + GW'(1);
                    col_next  = col_first_reg;
                    row_next  = row_reg + CW'(1);
                    addr_next = addr_reg + GLYPH_STEP;
                end
                else
                begin
                    gcol_next = gcol_reg + BW'(1);
                    col_next  = col_reg + CW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            rgblit_pkg::ST_RWAIT: pix_next = frame_q;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd_ready       = (state_reg == rgblit_pkg::ST_IDLE);
        res_valid       = (state_reg == rgblit_pkg::ST_DONE);
        res.read_pixel  = pix_reg;
        res.clipped     = clip_reg;

        frame_req.we    = (state_reg == rgblit_pkg::ST_FILL) ||
                          ((state_reg == rgblit_pkg::ST_GPIX) && glyph_bit && on_screen);
        frame_req.re    = (state_reg == rgblit_pkg::ST_RADDR);
        frame_req.addr  = addr_reg;
        frame_req.wdata = cmd_reg.color;

        font_req.we     = (state_reg == rgblit_pkg::ST_SETUP) &&
                          (cmd_reg.mode == rgblit_pkg::MODE_LOAD) && load_ok;
        font_req.re     = (state_reg == rgblit_pkg::ST_GFETCH) ||
                          ((state_reg == rgblit_pkg::ST_GPIX) && gcol_last && !grow_last);
        font_req.addr   = (state_reg == rgblit_pkg::ST_SETUP) ? load_addr : glyph_addr;
        font_req.wdata  = cmd_reg.glyph_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgblit_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        col_reg       <= col_next;
        row_reg       <= row_next;
        col_first_reg <= col_first_next;
        col_end_reg   <= col_end_next;
        row_end_reg   <= row_end_next;
        addr_reg      <= addr_next;
        step_reg      <= step_next;
        grow_reg      <= grow_next;
        gcol_reg      <= gcol_next;
        clip_reg      <= clip_next;
        pix_reg       <= pix_next;
    end

endmodule

// ===== hdl/rect_and_glyph_blitter.sv =====
`timescale 1ns / 1ps

// 2d drawing engine over a 480x320, 16 bit per pixel frame memory with an 8x16 font store.
// each input item is one command (clear screen, fill rectangle, draw glyph, load glyph row,
// read pixel) and returns exactly one result item (read pixel value, clipped flag).
// one item is worked on at a time and s_tready is low meanwhile; the frame memory has one
// port, so the walk writes one pixel per cycle. the result sits in an output register, so
// the next item is taken while it waits on m_tready. frame and font contents are undefined
// after reset: read back only what was written. pixels that land off the screen are
// dropped and flagged.

module rect_and_glyph_blitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode[2:0] x[11:3] y[20:12] rect_width[29:21] rect_height[38:30]
    // char_code[46:39] glyph_row[50:47] glyph_bits[58:51] color[74:59], zero above
    input  logic [rgblit_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_pixel[15:0] clipped[16], zero above
    output logic [rgblit_pkg::OUT_DATA_W-1:0]   m_tdata
);

    rgblit_pkg::cmd_t       cmd;
    rgblit_pkg::result_t    res;
    rgblit_pkg::frame_req_t frame_req;
    rgblit_pkg::font_req_t  font_req;
    logic [15:0]            frame_q;
    logic [7:0]             font_q;
    logic                   res_valid;
    logic                   out_free;

    logic                   m_tvalid_reg, m_tvalid_next;
    rgblit_pkg::result_t    res_reg;

    // unpack the input item, first field in the low bits
    assign cmd = rgblit_pkg::cmd_t'(s_tdata[$bits(rgblit_pkg::cmd_t)-1:0]);

    // output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    rgblit_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd       (cmd),
        .cmd_ready (s_tready),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .frame_req (frame_req),
        .frame_q   (frame_q),
        .font_req  (font_req),
        .font_q    (font_q)
    );

    rgblit_frame_mem u_frame_mem (
        .clk (clk),
        .req (frame_req),
        .q   (frame_q)
    );

    rgblit_font_mem u_font_mem (
        .clk (clk),
        .req (font_req),
        .q   (font_q)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && out_free)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded as the engine hands off its item
    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rgblit_pkg::OUT_DATA_W'(res_reg);

endmodule

// ===== tb/sv/rect_and_glyph_blitter_tb.sv =====
`timescale 1ns / 1ps

module rect_and_glyph_blitter_tb;
    import rgblit_pkg::*;

    // modes the block takes but ignores
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // a full-screen clear or fill moves nothing while it writes all 153600 pixels
    localparam int STALL_LIMIT = 600000;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        cmd_t    cmd;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow copies of the frame and font stores
    bit [15:0] frame_img [0:PIXELS-1];
    bit [7:0]  font_img [0:FONT_DEPTH-1];
    bit        font_row_loaded [0:FONT_DEPTH-1];
    bit        glyph_ready [0:GLYPH_COUNT-1];
    int        ready_codes[$];

    result_t   awaited_results[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        fail_count;
    int        results_seen;
    int        quiet_cycles;

    rect_and_glyph_blitter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 50)
        begin
            $display("mismatch on %s: got %h, want %h (result %0d, t=%0t)",
                     what, got, want, results_seen, $realtime);
        end
        fail_count++;
    endtask

    // result checker, oldest expectation first
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(result_t)-1:0];
            if (awaited_results.size() == 0)
            begin
                report_mismatch("unexpected item", int'(got), 0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.read_pixel !== want.read_pixel)
                begin
                    report_mismatch("read_pixel", int'(got.read_pixel), int'(want.read_pixel));
                end
                if (got.clipped !== want.clipped)
                begin
                    report_mismatch("clipped", int'(got.clipped), int'(want.clipped));
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // runs one command on the shadow stores and returns its result
    function automatic result_t predict_blit(input cmd_t c);
        result_t res;
        int      x_end;
        int      y_end;
        int      col;
        int      row;
        int      base;
        int      idx;
        bit      complete;
        res = '0;
        base = int'(c.char_code) * GLYPH_HEIGHT;
        case (c.mode)
            MODE_CLEAR:
            begin
                foreach (frame_img[i])
                    frame_img[i] = c.color;
            end
            MODE_FILL:
            begin
                // zero width or height writes nothing and never clips
                if (c.rect_width != 0 && c.rect_height != 0)
                begin
                    x_end = int'(c.x) + int'(c.rect_width);
                    y_end = int'(c.y) + int'(c.rect_height);
                    if (x_end > SCREEN_WIDTH)
                    begin
                        x_end = SCREEN_WIDTH;
                        res.clipped = 1'b1;
                    end
                    if (y_end > SCREEN_HEIGHT)
                    begin
                        y_end = SCREEN_HEIGHT;
                        res.clipped = 1'b1;
                    end
                    for (int r = int'(c.y); r < y_end; r++)
                        for (int k = int'(c.x); k < x_end; k++)
                            frame_img[r * SCREEN_WIDTH + k] = c.color;
                end
            end
            MODE_GLYPH:
            begin
                // only set bits are drawn, and only set bits off screen clip
                for (int r = 0; r < GLYPH_HEIGHT; r++)
                begin
                    for (int k = 0; k < GLYPH_WIDTH; k++)
                    begin
                        if (font_img[base + r][7 - k])
                        begin
                            col = int'(c.x) + k;
                            row = int'(c.y) + r;
                            if (col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT)
                                res.clipped = 1'b1;
                            else
                                frame_img[row * SCREEN_WIDTH + col] = c.color;
                        end
                    end
                end
            end
            MODE_LOAD:
            begin
                idx = base + int'(c.glyph_row);
                font_img[idx] = c.glyph_bits;
                font_row_loaded[idx] = 1'b1;
                if (!glyph_ready[c.char_code])
                begin
                    complete = 1'b1;
                    for (int r = 0; r < GLYPH_HEIGHT; r++)
                        complete &= font_row_loaded[base + r];
                    if (complete)
                    begin
                        glyph_ready[c.char_code] = 1'b1;
                        ready_codes.push_back(int'(c.char_code));
                    end
                end
            end
            MODE_READ:
            begin
                if (int'(c.x) < SCREEN_WIDTH && int'(c.y) < SCREEN_HEIGHT)
                    res.read_pixel = frame_img[int'(c.y) * SCREEN_WIDTH + int'(c.x)];
                else
                    res.clipped = 1'b1;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // drives one item at the falling edge and books its result when taken
    task automatic send_cmd(input cmd_t c, input bit typed, input result_t typed_want);
        result_t want;
        want = predict_blit(c);
        if (typed)
            want = typed_want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(c);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        awaited_results.push_back(want);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_t random_cmd();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(cmd_t)-1:0];
    endfunction

    function automatic plan_row_t row_of(input logic [2:0] mode, input int x, input int y,
                                         input int w, input int h, input int code,
                                         input int grow, input int gbits, input int color,
                                         input bit typed, input int pix, input bit clip);
        plan_row_t pr;
        pr.cmd.mode        = mode;
        pr.cmd.x           = 9'(x);
        pr.cmd.y           = 9'(y);
        pr.cmd.rect_width  = 9'(w);
        pr.cmd.rect_height = 9'(h);
        pr.cmd.char_code   = 8'(code);
        pr.cmd.glyph_row   = 4'(grow);
        pr.cmd.glyph_bits  = 8'(gbits);
        pr.cmd.color       = 16'(color);
        pr.typed           = typed;
        pr.want.read_pixel = 16'(pix);
        pr.want.clipped    = clip;
        return pr;
    endfunction

    // random commands; whole glyph loads are the well-formed sequences that
    // make draws possible, stray single-row loads and spare modes are noise
    task automatic random_burst(input int quota);
        int   done_items;
        int   pick;
        cmd_t c;
        done_items = 0;
        while (done_items < quota)
        begin
            c = random_cmd();
            pick = $urandom_range(999);
            if (pick < 2)
            begin
                c.mode = MODE_CLEAR;
                send_cmd(c, 1'b0, '0);
                done_items++;
            end
            else if (pick < 30 || (pick < 300 && ready_codes.size() == 0))
            begin
                c.mode = MODE_LOAD;
                for (int r = 0; r < GLYPH_HEIGHT; r++)
                begin
                    c.glyph_row  = 4'(r);
                    c.glyph_bits = 8'($urandom());
                    send_cmd(c, 1'b0, '0);
                end
                done_items += GLYPH_HEIGHT;
            end
            else if (pick < 60)
            begin
                c.mode = MODE_LOAD;
                send_cmd(c, 1'b0, '0);
                done_items++;
            end
            else if (pick < 300)
            begin
                c.mode = MODE_GLYPH;
                c.char_code = 8'(ready_codes[$urandom_range(ready_codes.size() - 1)]);
                if ($urandom_range(9) < 7)
                begin
                    c.x = 9'($urandom_range(SCREEN_WIDTH - GLYPH_WIDTH));
                    c.y = 9'($urandom_range(SCREEN_HEIGHT - GLYPH_HEIGHT));
                end
                send_cmd(c, 1'b0, '0);
                done_items++;
            end
            else if (pick < 540)
            begin
                c.mode = MODE_READ;
                if ($urandom_range(9) < 8)
                begin
                    c.x = 9'($urandom_range(SCREEN_WIDTH - 1));
                    c.y = 9'($urandom_range(SCREEN_HEIGHT - 1));
                end
                send_cmd(c, 1'b0, '0);
                done_items++;
            end
            else if (pick < 960)
            begin
                c.mode = MODE_FILL;
                // mostly small rectangles, now and then a large one
                if ($urandom_range(59) != 0)
                begin
                    c.rect_width  = 9'($urandom_range(16));
                    c.rect_height = 9'($urandom_range(16));
                end
                if ($urandom_range(9) < 7)
                begin
                    c.x = 9'($urandom_range(SCREEN_WIDTH - 1));
                    c.y = 9'($urandom_range(SCREEN_HEIGHT - 1));
                end
                send_cmd(c, 1'b0, '0);
                done_items++;
            end
            else
            begin
                c.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
                send_cmd(c, 1'b0, '0);
                done_items++;
            end
        end
    endtask

    initial
    begin : stimulus
        plan_row_t plan[$];
        int        send_pct[4];
        int        recv_pct[4];
        int        gbits;
        send_pct = '{0, 77, 0, 14};
        recv_pct = '{0, 0, 77, 14};
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        rst_n    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: mode, x, y, w, h, code, row, bits, color, typed, pixel, clip
        // the opening clear defines every pixel, so later reads are always legal
        plan.push_back(row_of(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 'h8000, 1, 0, 0));
        plan.push_back(row_of(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 'h8000, 0));
        plan.push_back(row_of(MODE_READ, 511, 511, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        plan.push_back(row_of(MODE_READ, 479, 320, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        // empty rectangle
        plan.push_back(row_of(MODE_FILL, 0, 0, 0, 320, 0, 0, 0, 'hFFFF, 1, 0, 0));
        // past the bottom right corner, and wholly off screen
        plan.push_back(row_of(MODE_FILL, 470, 310, 511, 511, 0, 0, 0, 'h7FFF, 1, 0, 1));
        plan.push_back(row_of(MODE_FILL, 511, 511, 1, 1, 0, 0, 0, 'hFFFF, 1, 0, 1));
        plan.push_back(row_of(MODE_READ, 479, 319, 0, 0, 0, 0, 0, 0, 1, 'h7FFF, 0));
        plan.push_back(row_of(MODE_SPARE_LO, 5, 5, 5, 5, 5, 5, 5, 5, 1, 0, 0));
        plan.push_back(row_of(MODE_SPARE_HI, 511, 511, 511, 511, 255, 15, 255, 'hFFFF,
                              1, 0, 0));
        // whole glyph for the top code, then drawn across the corner
        for (int r = 0; r < GLYPH_HEIGHT; r++)
        begin
            gbits = (r == 0) ? 'hFF : (r == 7) ? 'h00 : (r == 15) ? 'h80 : (1 << (r % 8));
            plan.push_back(row_of(MODE_LOAD, 0, 0, 0, 0, 255, r, gbits, 0, 1, 0, 0));
        end
        plan.push_back(row_of(MODE_GLYPH, 476, 312, 0, 0, 255, 0, 0, 'h1234, 0, 0, 0));
        plan.push_back(row_of(MODE_READ, 476, 312, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // full-screen fill
        plan.push_back(row_of(MODE_FILL, 0, 0, 480, 320, 0, 0, 0, 'h0000, 1, 0, 0));

        foreach (plan[i])
            send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);

        // random phases; the sender holds off until the block drains between them
        for (int p = 0; p < 4; p++)
        begin
            wait_for_results();
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            random_burst(PHASE_ITEMS);
        end

        wait_for_results();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
